// File: hdl/orq_pkg.sv
// package for the ordered ready queue: widths, operation and status codes,
// entry and cell control types; no dependencies
package orq_pkg;

   localparam int CAPACITY = 16;
   localparam int ID_W     = 8;
   localparam int RANK_W   = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      MODE_TAIL    = 2'd0,
      MODE_FRONT   = 2'd1,
      MODE_ORDERED = 2'd2,
      MODE_POP     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [RANK_W-1:0] rank;
   } entry_type;

   // broadcast to every cell of the row
   typedef struct packed {
      mode_type  mode;
      logic      push;   // accepted insert that fits
      logic      pop;    // accepted pop of a non-empty queue
      entry_type item;
   } cell_op_type;

endpackage

// File: hdl/orq_if.sv
// request and response channel interfaces of the ordered ready queue
// depends on orq_pkg
interface orq_req_if import orq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic [ID_W-1:0]          item_id;
   logic signed [RANK_W-1:0] item_rank;

   modport source(output valid, mode, item_id, item_rank, input ready);
   modport sink(input valid, mode, item_id, item_rank, output ready);
endinterface

interface orq_rsp_if import orq_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [ID_W-1:0]          popped_id;
   logic signed [RANK_W-1:0] popped_rank;
   logic [CNT_W-1:0]         queue_length;

   modport source(output valid, status, popped_id, popped_rank, queue_length,
                  input ready);
   modport sink(input valid, status, popped_id, popped_rank, queue_length,
                output ready);
endinterface

// File: hdl/orq_cell.sv
// one slot of the queue row: holds an entry, shifts toward tail on insert,
// toward head on pop; depends on orq_pkg
module orq_cell import orq_pkg::*; (
   input  logic        clock,
   input  cell_op_type op,
   input  logic        occ,        // slot holds a stored entry
   input  logic        is_tail,    // first free slot
   input  logic        is_head,
   input  logic        found_in,   // insert point lies before this slot
   input  entry_type   left_ent,
   input  entry_type   right_ent,
   output logic        found_out,
   output entry_type   ent
);

   entry_type ent_ff;
   entry_type ent_in;
   logic      hit;

   always_comb begin
      case (op.mode)
         MODE_TAIL:    hit = is_tail;
         MODE_FRONT:   hit = is_head;
         MODE_ORDERED: hit = occ ? (ent_ff.rank > op.item.rank) : is_tail;
         default:      hit = 1'b0;
      endcase
   end

   assign found_out = found_in | hit;

   always_comb begin
      ent_in = ent_ff;
      if (op.push) begin
         if (found_in) begin
            ent_in = left_ent;
         end else if (hit) begin
            ent_in = op.item;
         end
      end else if (op.pop) begin
         ent_in = right_ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent = ent_ff;

endmodule

// File: hdl/ordered_ready_queue_unit.sv
// top level of the ordered ready queue: row of orq_cell slots, length
// counter and response register; depends on orq_pkg, orq_if, orq_cell
//
// usage
//   req channel: one request per operation (mode, item_id, item_rank);
//     mode push tail, push front, ordered insert (before the first entry
//     of strictly greater rank, equal ranks stay in arrival order), pop head
//   rsp channel: exactly one response per request, in request order,
//     with status, popped id and rank (zero unless a pop succeeds) and the
//     queue length after the operation
//   timing: the response is valid in the cycle after the request is taken
//   throughput: one request per cycle while responses are taken; every
//     slot updates in parallel and the insert point is found by a ripple
//     through the cell row, so the row length sets the critical path
//   stall: a held response blocks new requests only while rsp.ready is
//     low; the request and the waiting response are parted by the response
//     register
//   reset: synchronous, active high; the queue comes up empty and no
//     response is pending; slot contents need no clearing
module ordered_ready_queue_unit import orq_pkg::*; (
   input  logic clock,
   input  logic reset,
   orq_req_if.sink   req_ch,
   orq_rsp_if.source rsp_ch
);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic [ID_W-1:0]          popped_id_ff, popped_id_in;
   logic signed [RANK_W-1:0] popped_rank_ff, popped_rank_in;

   logic        accept;
   logic        is_pop;
   logic        full;
   logic        empty;
   cell_op_type op;
   entry_type   ents [CAPACITY];
   logic        found [CAPACITY+1];

   // a new request is taken unless a response is stuck in the register
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_pop = (mode_type'(req_ch.mode) == MODE_POP);
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);

   // one operation broadcast to the whole row
   always_comb begin
      op.mode      = mode_type'(req_ch.mode);
      op.push      = accept && !is_pop && !full;
      op.pop       = accept && is_pop && !empty;
      op.item.id   = req_ch.item_id;
      op.item.rank = req_ch.item_rank;
   end

   // insert point chain starts clear at the head
   assign found[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_ent;
      entry_type right_ent;

      if (i == 0) begin : g_head
         assign left_ent = op.item;
      end else begin : g_mid
         assign left_ent = ents[i-1];
      end

      // last slot has no right neighbor, its content is don't care on pop
      if (i == CAPACITY - 1) begin : g_last
         assign right_ent = ents[i];
      end else begin : g_inner
         assign right_ent = ents[i+1];
      end

      orq_cell u_cell (
         .clock     (clock),
         .op        (op),
         .occ       (CNT_W'(i) < count_ff),
         .is_tail   (CNT_W'(i) == count_ff),
         .is_head   (i == 0),
         .found_in  (found[i]),
         .left_ent  (left_ent),
         .right_ent (right_ent),
         .found_out (found[i+1]),
         .ent       (ents[i])
      );
   end

   // length counter and response contents
   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      popped_id_in   = popped_id_ff;
      popped_rank_in = popped_rank_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in   = 1'b1;
         status_in      = ST_DONE;
         popped_id_in   = '0;
         popped_rank_in = '0;
         if (is_pop) begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               // head slot leaves the queue
               popped_id_in   = ents[0].id;
               popped_rank_in = ents[0].rank;
               count_in       = count_ff - CNT_W'(1);
            end
         end else if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      popped_id_ff   <= popped_id_in;
      popped_rank_ff <= popped_rank_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.popped_id    = popped_id_ff;
   assign rsp_ch.popped_rank  = popped_rank_ff;
   assign rsp_ch.queue_length = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("queue length beyond capacity");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && is_pop && !empty) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("successful pop did not shorten the queue");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_FULL) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("full status with queue not full");

   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_EMPTY) |-> (count_ff == '0 && popped_id_ff == '0))
      else $error("empty status with stored entries or nonzero id");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !accept)
      else $error("request taken while response stalled");
`endif

endmodule

// File: tb/tb_ordered_ready_queue_unit.sv
`timescale 1ns / 1ps
// testbench for ordered_ready_queue_unit: directed and random request streams
// checked against a shadow copy of the ordered queue; depends on orq_pkg, orq_if
module tb_ordered_ready_queue_unit import orq_pkg::*; ;

   // cycles with no handshake on either channel before the run is abandoned
   localparam int WATCHDOG_LIMIT   = 4000;
   // idle margin after the last response has come back, before the final check
   localparam int DRAIN_CYCLES     = 4;
   localparam int RANDOM_REQUESTS  = 1400;
   localparam int LONG_HOLD_CYCLES = 120;

   typedef struct {
      status_type               status;
      logic [ID_W-1:0]          id;
      logic signed [RANK_W-1:0] rank;
      logic [CNT_W-1:0]         length;
   } reply_type;

   // shadow ordered queue plus the replies it predicts, oldest first
   class queue_reply_checker;
      entry_type shadow_entries[$];
      reply_type pending_replies[$];
      int        mismatches;
      int        mode_count[4];
      int        full_count;
      int        empty_count;

      function void note_request(mode_type mode, logic [ID_W-1:0] id,
                                 logic signed [RANK_W-1:0] rank);
         reply_type reply;
         entry_type item;
         int        pos;
         reply.status = ST_DONE;
         reply.id     = '0;
         reply.rank   = '0;
         item.id      = id;
         item.rank    = rank;
         mode_count[mode]++;
         if (mode == MODE_POP) begin
            if (shadow_entries.size() == 0) begin
               reply.status = ST_EMPTY;
               empty_count++;
            end else begin
               item       = shadow_entries.pop_front();
               reply.id   = item.id;
               reply.rank = item.rank;
            end
         end else if (shadow_entries.size() >= CAPACITY) begin
            reply.status = ST_FULL;
            full_count++;
         end else if (mode == MODE_TAIL) begin
            shadow_entries.push_back(item);
         end else if (mode == MODE_FRONT) begin
            shadow_entries.push_front(item);
         end else begin
            // stable insert: go past every entry of equal or smaller rank
            pos = 0;
            while (pos < shadow_entries.size() &&
                   $signed(shadow_entries[pos].rank) <= $signed(rank))
               pos++;
            shadow_entries.insert(pos, item);
         end
         reply.length = CNT_W'(shadow_entries.size());
         pending_replies.push_back(reply);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
      endfunction

      function void compare_field(string name, longint expv, longint got);
         if (expv != got)
            report($sformatf("%s expected %0d actual %0d", name, expv, got));
      endfunction

      function void check_response(logic [1:0] status, logic [ID_W-1:0] id,
                                   logic signed [RANK_W-1:0] rank,
                                   logic [CNT_W-1:0] length);
         reply_type reply;
         if (pending_replies.size() == 0) begin
            report("response with no request waiting");
            return;
         end
         reply = pending_replies.pop_front();
         compare_field("status", reply.status, status);
         compare_field("popped_id", reply.id, id);
         compare_field("popped_rank", reply.rank, rank);
         compare_field("queue_length", reply.length, length);
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void close_out();
         if (pending_replies.size() != 0)
            report($sformatf("%0d responses never arrived", pending_replies.size()));
      endfunction
   endclass

   logic clock;
   logic reset;

   orq_req_if req_ch();
   orq_rsp_if rsp_ch();

   ordered_ready_queue_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   queue_reply_checker reply_book = new();

   // phase controls shared by the sender and the receiver
   logic burst_phase;    // no idling on either side
   logic hold_request;   // ask the receiver for one long hold-off
   int   idle_cycles;
   int   random_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // reset held at the start of the run, once
   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // monitor: note every accepted request, check every accepted response,
   // and watch for a hung handshake
   always @(posedge clock) begin
      if (req_ch.valid && req_ch.ready)
         reply_book.note_request(mode_type'(req_ch.mode), req_ch.item_id,
                                 req_ch.item_rank);
      if (rsp_ch.valid && rsp_ch.ready)
         reply_book.check_response(rsp_ch.status, rsp_ch.popped_id,
                                   rsp_ch.popped_rank, rsp_ch.queue_length);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, short and long, none during a burst phase,
   // and one long hold-off on demand counted here
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
         end else if (burst_phase) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ($urandom_range(99)) inside
               [0:69]:  rsp_ch.ready <= 1'b1;
               [70:95]: rsp_ch.ready <= 1'b0;
               default: begin
                  stall_left = $urandom_range(30, 8);
                  rsp_ch.ready <= 1'b0;
               end
            endcase
         end
      end
   end

   // hold the request until it is taken; valid stays up for the next one
   task automatic send_request(mode_type mode, logic [ID_W-1:0] id,
                               logic signed [RANK_W-1:0] rank);
      req_ch.valid     <= 1'b1;
      req_ch.mode      <= mode;
      req_ch.item_id   <= id;
      req_ch.item_rank <= rank;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // mostly back to back, sometimes a short gap, rarely a long gap; no gap in a burst phase
   function automatic int pick_gap();
      int roll;
      if (burst_phase)
         return 0;
      roll = $urandom_range(99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // ranks crowd around zero for ties, hit the extremes, or range freely
   function automatic logic signed [RANK_W-1:0] pick_rank();
      logic signed [RANK_W-1:0] rank;
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) begin
         rank = RANK_W'($urandom_range(8));
         rank = rank - 16'sd4;
      end else if (roll < 55) begin
         case ($urandom_range(6))
            0:       rank = 16'sh8000;
            1:       rank = 16'sh8001;
            2:       rank = -16'sd1;
            3:       rank = 16'sd0;
            4:       rank = 16'sd1;
            5:       rank = 16'sh7FFE;
            default: rank = 16'sh7FFF;
         endcase
      end else begin
         rank = RANK_W'($urandom_range(65535));
      end
      return rank;
   endfunction

   task automatic send_random(int insert_pct);
      mode_type mode;
      if ($urandom_range(99) < insert_pct)
         mode = mode_type'($urandom_range(2));
      else
         mode = MODE_POP;
      // pops still carry random id and rank, the block must ignore them
      send_request(mode, ID_W'($urandom_range(255)), pick_rank());
      random_sent++;
      idle_sender(pick_gap());
   endtask

   // one edge first so the monitor has noted the last accepted request
   task automatic wait_drained();
      @(posedge clock);
      while (reply_book.pending() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int phase;
      int phase_len;
      int insert_pct;
      req_ch.valid     <= 1'b0;
      req_ch.mode      <= MODE_TAIL;
      req_ch.item_id   <= '0;
      req_ch.item_rank <= '0;
      burst_phase      <= 1'b0;
      hold_request     <= 1'b0;
      idle_cycles      = 0;
      random_sent      = 0;
      @(negedge reset);
      @(posedge clock);

      // directed: pop of an empty queue
      send_request(MODE_POP, 8'h3C, 16'sh1234);
      // extremes of id and rank, every insert mode, equal ranks in arrival order
      send_request(MODE_TAIL, 8'h00, 16'sh8000);
      send_request(MODE_TAIL, 8'hFF, 16'sh7FFF);
      send_request(MODE_FRONT, 8'hA5, 16'sd0);
      send_request(MODE_ORDERED, 8'h5A, 16'sd0);
      send_request(MODE_ORDERED, 8'h11, 16'sh8000);
      send_request(MODE_ORDERED, 8'h22, 16'sh7FFF);
      send_request(MODE_ORDERED, 8'h33, -16'sd1);
      // fill the rest of the queue
      for (int i = 0; i < 9; i++)
         send_request(mode_type'(i % 3), ID_W'(8'h80 + i), RANK_W'(i - 4));
      // inserts refused on a full queue, in every mode
      send_request(MODE_TAIL, 8'hEE, 16'sd7);
      send_request(MODE_FRONT, 8'hDD, 16'sh8000);
      send_request(MODE_ORDERED, 8'hCC, 16'sd0);
      // a few pops from the head
      repeat (4) send_request(MODE_POP, 8'hFF, 16'shFFFF);
      idle_sender(1);
      wait_drained();

      // random phases: filling, draining and balanced, some in bursts
      phase = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         case ($urandom_range(2))
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 50;
         endcase
         phase_len = $urandom_range(40, 10);
         if (phase == 3) begin
            // receiver holds off while requests keep coming back to back
            burst_phase  <= 1'b1;
            hold_request <= 1'b1;
            insert_pct = 70;
            phase_len  = 40;
         end else begin
            burst_phase <= ($urandom_range(3) == 0);
         end
         if (phase == 8 || phase % 11 == 10) begin
            // sender pauses until every response has come back
            idle_sender(1);
            wait_drained();
         end
         repeat (phase_len) send_random(insert_pct);
         phase++;
      end

      idle_sender(1);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      reply_book.close_out();

      $display("covered %0d requests: %0d push tail, %0d push front, %0d ordered, %0d pop",
               reply_book.mode_count.sum(), reply_book.mode_count[MODE_TAIL],
               reply_book.mode_count[MODE_FRONT], reply_book.mode_count[MODE_ORDERED],
               reply_book.mode_count[MODE_POP]);
      $display("%0d inserts refused as full, %0d pops on empty, %0d mismatches",
               reply_book.full_count, reply_book.empty_count, reply_book.mismatches);
      if (reply_book.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
hdl/orq_pkg.sv
hdl/orq_if.sv
hdl/orq_cell.sv
hdl/ordered_ready_queue_unit.sv
tb/tb_ordered_ready_queue_unit.sv
